// ----- design/base64_decoder_defines.svh -----
// assertion macros used by the base64 decoder top module (base64_decoder.sv)
// no dependencies; assertions vanish when SYNTH is defined
`ifndef BASE64_DECODER_DEFINES_SVH
`define BASE64_DECODER_DEFINES_SVH
`ifndef SYNTH
`define B64D_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("base64 decoder assertion failed");
`define B64D_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("base64 decoder assertion failed");
`else
`define B64D_ASSERT_SAME(lbl, ante, cons)
`define B64D_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- design/b64d_pkg.sv -----
// types, constants and the character decode table of the base64 decoder
// used by every module of the design; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package b64d_pkg;

  typedef enum logic [1:0] {
    ST_NOPAD = 2'd0,
    ST_PAD   = 2'd1,
    ST_ERR   = 2'd2
  } status_t;

  typedef enum logic {
    KIND_DATA   = 1'b0,
    KIND_STATUS = 1'b1
  } kind_t;

  localparam logic [7:0] CH_PAD   = 8'h3d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [5:0] SX_PLUS  = 6'h3e;
  localparam logic [5:0] SX_SLASH = 6'h3f;

  // results caused by one request: data bytes then an optional status
  typedef struct packed {
    logic [1:0] nbytes;
    logic       has_status;
    status_t    status;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
  } bundle_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    status_t    status;
  } entry_t;

  // {invalid, sextet}; sextet is zero for a non-alphabet character
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [6:0] r;
    r = 7'h40;
    if (c inside {[8'h41:8'h5a]}) r = {1'b0, 6'(c - 8'h41)};
    else if (c inside {[8'h61:8'h7a]}) r = {1'b0, 6'(c - 8'h47)};
    else if (c inside {[8'h30:8'h39]}) r = {1'b0, 6'(c + 8'h04)};
    else if (c == CH_PLUS) r = {1'b0, SX_PLUS};
    else if (c == CH_SLASH) r = {1'b0, SX_SLASH};
    return r;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return c inside {CH_LF, CH_CR, CH_SPACE, CH_TAB};
  endfunction

endpackage

`default_nettype wire

// ----- design/b64d_quad.sv -----
// quad assembly state and per-character decode of the base64 decoder
// depends on b64d_pkg
`timescale 1ns / 1ps
`default_nettype none

module b64d_quad (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            en,
  input  wire logic [7:0]      char_in,
  input  wire logic            present,
  input  wire logic            at_end,
  output b64d_pkg::bundle_t    bundle
);

  logic [5:0]        sx_r [3];
  logic [5:0]        sx_nxt [3];
  logic [1:0]        fill_r, fill_nxt;
  logic              bad_r, bad_nxt;
  logic              tpad_r, tpad_nxt;
  logic              fin_r, fin_nxt;
  b64d_pkg::status_t fcode_r, fcode_nxt;

  logic [6:0] sx;
  logic       ok;
  logic       is_pad;

  assign sx     = b64d_pkg::sextet_of(char_in);
  assign ok     = !sx[6];
  assign is_pad = (char_in == b64d_pkg::CH_PAD);

  always_comb begin
    sx_nxt    = sx_r;
    fill_nxt  = fill_r;
    bad_nxt   = bad_r;
    tpad_nxt  = tpad_r;
    fin_nxt   = fin_r;
    fcode_nxt = fcode_r;
    bundle.nbytes     = 2'd0;
    bundle.has_status = at_end;
    bundle.b0 = {sx_r[0], sx_r[1][5:4]};
    bundle.b1 = {sx_r[1][3:0], sx_r[2][5:2]};
    bundle.b2 = {sx_r[2][1:0], sx[5:0]};
    if (present && !fin_r) begin
      case (fill_r)
        2'd0: begin
          if (ok || !b64d_pkg::is_blank(char_in)) begin
            if (!ok) bad_nxt = 1'b1;
            sx_nxt[0] = sx[5:0];
            fill_nxt  = 2'd1;
          end
        end
        2'd1: begin
          if (!ok) bad_nxt = 1'b1;
          sx_nxt[1] = sx[5:0];
          fill_nxt  = 2'd2;
        end
        2'd2: begin
          if (!ok) begin
            if (is_pad) tpad_nxt = 1'b1;
            else bad_nxt = 1'b1;
          end
          sx_nxt[2] = sx[5:0];
          fill_nxt  = 2'd3;
        end
        default: begin
          if (bad_r) begin
            fin_nxt   = 1'b1;
            fcode_nxt = b64d_pkg::ST_ERR;
          end else if (tpad_r) begin
            if (is_pad) begin
              bundle.nbytes = 2'd1;
              fcode_nxt     = b64d_pkg::ST_PAD;
            end else begin
              fcode_nxt = b64d_pkg::ST_ERR;
            end
            fin_nxt = 1'b1;
          end else if (!ok) begin
            if (is_pad) begin
              bundle.nbytes = 2'd2;
              fcode_nxt     = b64d_pkg::ST_PAD;
            end else begin
              fcode_nxt = b64d_pkg::ST_ERR;
            end
            fin_nxt = 1'b1;
          end else begin
            bundle.nbytes = 2'd3;
          end
          sx_nxt[0] = 6'd0;
          sx_nxt[1] = 6'd0;
          sx_nxt[2] = 6'd0;
          fill_nxt  = 2'd0;
          bad_nxt   = 1'b0;
          tpad_nxt  = 1'b0;
        end
      endcase
    end
    bundle.status = fcode_nxt;
    if (at_end) begin
      sx_nxt[0] = 6'd0;
      sx_nxt[1] = 6'd0;
      sx_nxt[2] = 6'd0;
      fill_nxt  = 2'd0;
      bad_nxt   = 1'b0;
      tpad_nxt  = 1'b0;
      fin_nxt   = 1'b0;
      fcode_nxt = b64d_pkg::ST_NOPAD;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sx_r[0] <= 6'd0;
      sx_r[1] <= 6'd0;
      sx_r[2] <= 6'd0;
      fill_r  <= 2'd0;
      bad_r   <= 1'b0;
      tpad_r  <= 1'b0;
      fin_r   <= 1'b0;
      fcode_r <= b64d_pkg::ST_NOPAD;
    end else if (en) begin
      sx_r    <= sx_nxt;
      fill_r  <= fill_nxt;
      bad_r   <= bad_nxt;
      tpad_r  <= tpad_nxt;
      fin_r   <= fin_nxt;
      fcode_r <= fcode_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- design/b64d_outq.sv -----
// result register of the base64 decoder: holds up to four results of one
// request and hands them out one per cycle while take is high; depends on b64d_pkg
`timescale 1ns / 1ps
`default_nettype none

module b64d_outq (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              load,
  input  wire b64d_pkg::bundle_t bundle,
  input  wire logic              take,
  output b64d_pkg::entry_t       head,
  output logic [2:0]             pend
);

  b64d_pkg::entry_t ent_r [4];
  b64d_pkg::entry_t ent_nxt [4];
  b64d_pkg::entry_t ld [4];
  b64d_pkg::entry_t st_e;
  logic [2:0]       cnt_r, cnt_nxt;

  always_comb begin
    st_e = '{kind: b64d_pkg::KIND_STATUS, data: 8'h00, status: bundle.status};
    ld[0] = (bundle.nbytes >= 2'd1) ?
            '{kind: b64d_pkg::KIND_DATA, data: bundle.b0, status: b64d_pkg::ST_NOPAD} : st_e;
    ld[1] = (bundle.nbytes >= 2'd2) ?
            '{kind: b64d_pkg::KIND_DATA, data: bundle.b1, status: b64d_pkg::ST_NOPAD} : st_e;
    ld[2] = (bundle.nbytes == 2'd3) ?
            '{kind: b64d_pkg::KIND_DATA, data: bundle.b2, status: b64d_pkg::ST_NOPAD} : st_e;
    ld[3] = st_e;
    ent_nxt = ent_r;
    cnt_nxt = cnt_r;
    if (load) begin
      ent_nxt = ld;
      cnt_nxt = 3'({1'b0, bundle.nbytes}) + 3'({2'b00, bundle.has_status});
    end else if (take) begin
      ent_nxt[0] = ent_r[1];
      ent_nxt[1] = ent_r[2];
      ent_nxt[2] = ent_r[3];
      cnt_nxt    = cnt_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 3'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  assign head = ent_r[0];
  assign pend = cnt_r;

endmodule

`default_nettype wire

// ----- design/base64_decoder.sv -----
// output: the first result is registered and appears in the cycle after the request is accepted
// throughput: one character per cycle while each gives at most one result and the
// output is not stalled; a character that gives more results holds the input until
// the single result register has drained its queue of up to four entries to one
// reset: synchronous active-low rst_n clears quad state and the result queue
`timescale 1ns / 1ps
`default_nettype none
`include "base64_decoder_defines.svh"

module base64_decoder (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // in_char
  input  wire logic [0:0]  in_tuser,   // char_present
  input  wire logic        in_tlast,   // end_of_input
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // out_byte, end_status, zero fill
  output logic [0:0]       out_tuser,  // result_kind
  output logic             out_tlast   // last_of_run
);

  b64d_pkg::bundle_t bundle;
  b64d_pkg::entry_t  head;
  logic [2:0]        pend;
  logic              acc;
  logic              take;

  assign take      = out_tvalid && out_tready;
  assign in_tready = (pend == 3'd0) || ((pend == 3'd1) && out_tready);
  assign acc       = in_tvalid && in_tready;

  b64d_quad u_quad (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (acc),
    .char_in (in_tdata),
    .present (in_tuser[0]),
    .at_end  (in_tlast),
    .bundle  (bundle)
  );

  b64d_outq u_outq (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (acc),
    .bundle (bundle),
    .take   (take),
    .head   (head),
    .pend   (pend)
  );

  assign out_tvalid = (pend != 3'd0);
  assign out_tdata  = {6'd0, head.status, head.data};
  assign out_tuser  = head.kind;
  assign out_tlast  = (pend == 3'd1);

  `B64D_ASSERT_SAME(a_no_overrun, in_tvalid && in_tready, pend <= 3'd1)
  `B64D_ASSERT_SAME(a_status_last, out_tvalid && out_tuser[0], out_tlast)
  `B64D_ASSERT_NEXT(a_end_reports, in_tvalid && in_tready && in_tlast, out_tvalid)

endmodule

`default_nettype wire

// ----- dv/base64_decoder_test.sv -----
// self-checking testbench for the base64 decoder: directed and random encoded texts
// predicts every decoded byte and end status and checks them in order; needs b64d_pkg
`timescale 1ns / 1ps

module base64_decoder_test;

  typedef struct packed {
    b64d_pkg::kind_t   kind;
    logic [7:0]        data;
    b64d_pkg::status_t status;
    logic              last;
  } result_t;

  typedef enum int {
    TAIL_CLEAN,
    TAIL_PAD1,
    TAIL_PAD2,
    TAIL_PARTIAL,
    TAIL_CORRUPT,
    TAIL_BADPAD,
    TAIL_NOISE
  } tail_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic [0:0]  in_tuser;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  logic [0:0]  out_tuser;
  logic        out_tlast;

  result_t pending_results[$];
  int      errors;
  int      live_chars;
  bit      idling;

  // decoder state as predicted
  logic [5:0]        quad_sx[3];
  logic [1:0]        quad_fill;
  logic              quad_bad;
  logic              quad_pad3;
  logic              text_done;
  b64d_pkg::status_t text_code;

  base64_decoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int sextet_value(input logic [7:0] c);
    if (c >= "A" && c <= "Z") return c - "A";
    if (c >= "a" && c <= "z") return c - "a" + 26;
    if (c >= "0" && c <= "9") return c - "0" + 52;
    if (c == b64d_pkg::CH_PLUS) return b64d_pkg::SX_PLUS;
    if (c == b64d_pkg::CH_SLASH) return b64d_pkg::SX_SLASH;
    return -1;
  endfunction

  function automatic bit blank_char(input logic [7:0] c);
    return c == b64d_pkg::CH_SPACE || c == b64d_pkg::CH_TAB ||
           c == b64d_pkg::CH_CR || c == b64d_pkg::CH_LF;
  endfunction

  function automatic logic [7:0] pick_alpha();
    string alphabet;
    alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    return alphabet[$urandom_range(0, 63)];
  endfunction

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(0, 3))
      0: return b64d_pkg::CH_SPACE;
      1: return b64d_pkg::CH_TAB;
      2: return b64d_pkg::CH_CR;
      default: return b64d_pkg::CH_LF;
    endcase
  endfunction

  function automatic tail_t pick_tail();
    case ($urandom_range(0, 9))
      0, 1, 2: return TAIL_CLEAN;
      3: return TAIL_PAD1;
      4: return TAIL_PAD2;
      5: return TAIL_PARTIAL;
      6, 7: return TAIL_CORRUPT;
      8: return TAIL_BADPAD;
      default: return TAIL_NOISE;
    endcase
  endfunction

  task automatic report_error(input string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endtask

  task automatic push_result(input b64d_pkg::kind_t kind, input logic [7:0] data,
                             input b64d_pkg::status_t status);
    result_t r;
    r.kind = kind;
    r.data = data;
    r.status = status;
    r.last = 1'b0;
    pending_results.push_back(r);
  endtask

  task automatic clear_quad();
    quad_sx[0] = '0;
    quad_sx[1] = '0;
    quad_sx[2] = '0;
    quad_fill = 2'd0;
    quad_bad = 1'b0;
    quad_pad3 = 1'b0;
  endtask

  // works out the results that one accepted request causes
  task automatic predict_decode(input logic [7:0] ch, input logic present, input logic fin);
    int         v;
    bit         ok;
    logic [5:0] sx;
    logic [7:0] b0, b1, b2;
    int         n0;
    result_t    r;
    n0 = pending_results.size();
    if (present && !text_done) begin
      live_chars++;
      v = sextet_value(ch);
      ok = v >= 0;
      sx = ok ? v[5:0] : 6'd0;
      case (quad_fill)
        2'd0: begin
          if (ok || !blank_char(ch)) begin
            if (!ok) quad_bad = 1'b1;
            quad_sx[0] = sx;
            quad_fill = 2'd1;
          end
        end
        2'd1: begin
          if (!ok) quad_bad = 1'b1;
          quad_sx[1] = sx;
          quad_fill = 2'd2;
        end
        2'd2: begin
          if (!ok) begin
            if (ch == b64d_pkg::CH_PAD) quad_pad3 = 1'b1;
            else quad_bad = 1'b1;
          end
          quad_sx[2] = sx;
          quad_fill = 2'd3;
        end
        default: begin
          b0 = {quad_sx[0], quad_sx[1][5:4]};
          b1 = {quad_sx[1][3:0], quad_sx[2][5:2]};
          b2 = {quad_sx[2][1:0], sx};
          if (quad_bad) begin
            text_done = 1'b1;
            text_code = b64d_pkg::ST_ERR;
          end else if (quad_pad3) begin
            if (ch == b64d_pkg::CH_PAD) begin
              push_result(b64d_pkg::KIND_DATA, b0, b64d_pkg::ST_NOPAD);
              text_code = b64d_pkg::ST_PAD;
            end else begin
              text_code = b64d_pkg::ST_ERR;
            end
            text_done = 1'b1;
          end else if (!ok) begin
            if (ch == b64d_pkg::CH_PAD) begin
              push_result(b64d_pkg::KIND_DATA, b0, b64d_pkg::ST_NOPAD);
              push_result(b64d_pkg::KIND_DATA, b1, b64d_pkg::ST_NOPAD);
              text_code = b64d_pkg::ST_PAD;
            end else begin
              text_code = b64d_pkg::ST_ERR;
            end
            text_done = 1'b1;
          end else begin
            push_result(b64d_pkg::KIND_DATA, b0, b64d_pkg::ST_NOPAD);
            push_result(b64d_pkg::KIND_DATA, b1, b64d_pkg::ST_NOPAD);
            push_result(b64d_pkg::KIND_DATA, b2, b64d_pkg::ST_NOPAD);
          end
          clear_quad();
        end
      endcase
    end
    if (fin) begin
      live_chars++;
      push_result(b64d_pkg::KIND_STATUS, 8'h00, text_code);
      clear_quad();
      text_done = 1'b0;
      text_code = b64d_pkg::ST_NOPAD;
    end
    if (pending_results.size() > n0) begin
      r = pending_results.pop_back();
      r.last = 1'b1;
      pending_results.push_back(r);
    end
  endtask

  // called and returns at a falling edge
  task automatic send_char(input logic [7:0] ch, input logic present, input logic fin);
    if (idling && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= ch;
    in_tuser <= present;
    in_tlast <= fin;
    do @(posedge clk); while (!in_tready);
    predict_decode(ch, present, fin);
    @(negedge clk);
  endtask

  task automatic send_chars(input string s, input bit fin);
    for (int i = 0; i < s.len(); i++) send_char(s[i], 1'b1, fin && i == s.len() - 1);
  endtask

  task automatic send_text(input int nquads, input tail_t tail);
    logic [7:0] text[$];
    int         base;
    int         k;
    bit         end_on_char;
    for (int q = 0; q < nquads; q++) begin
      if ($urandom_range(0, 3) == 0) text.push_back(pick_blank());
      repeat (4) text.push_back(pick_alpha());
    end
    case (tail)
      TAIL_PAD1: begin
        repeat (3) text.push_back(pick_alpha());
        text.push_back(b64d_pkg::CH_PAD);
      end
      TAIL_PAD2: begin
        repeat (2) text.push_back(pick_alpha());
        repeat (2) text.push_back(b64d_pkg::CH_PAD);
      end
      TAIL_PARTIAL: repeat ($urandom_range(1, 3)) text.push_back(pick_alpha());
      TAIL_CORRUPT: begin
        repeat (4) text.push_back(pick_alpha());
        text[$urandom_range(0, text.size() - 1)] = 8'($urandom_range(0, 255));
      end
      TAIL_BADPAD: begin
        repeat (4) text.push_back(pick_alpha());
        base = text.size() - 4;
        k = $urandom_range(0, 2);
        text[base + k] = b64d_pkg::CH_PAD;
        if (k < 2 && $urandom_range(0, 1) == 1) text[base + 3] = b64d_pkg::CH_PAD;
      end
      TAIL_NOISE: repeat ($urandom_range(1, 8)) text.push_back(8'($urandom_range(0, 255)));
      default: ;
    endcase
    // characters after the padding are dropped by the block
    if ((tail == TAIL_PAD1 || tail == TAIL_PAD2) && $urandom_range(0, 2) == 0)
      repeat ($urandom_range(1, 3)) text.push_back(pick_alpha());
    end_on_char = text.size() != 0 && $urandom_range(0, 1) == 1;
    foreach (text[i]) begin
      if ($urandom_range(0, 15) == 0) send_char(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_char(text[i], 1'b1, end_on_char && i == text.size() - 1);
    end
    if (!end_on_char) send_char(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic test_directed();
    send_chars(" \n", 1'b0);
    send_chars("+/09", 1'b0);
    send_char(8'h5a, 1'b0, 1'b0);
    send_chars("TQ==", 1'b0);
    send_chars("A", 1'b0);
    send_char(8'h00, 1'b0, 1'b1);
    send_chars("TWE=", 1'b1);
    // bad start, then whitespace inside the quad
    send_char(8'hff, 1'b1, 1'b0);
    send_char(b64d_pkg::CH_TAB, 1'b1, 1'b0);
    send_char(b64d_pkg::CH_CR, 1'b1, 1'b0);
    send_char(8'h00, 1'b1, 1'b1);
    send_chars("TWFu", 1'b1);
    send_chars("z", 1'b0);
    send_char(8'hff, 1'b0, 1'b1);
  endtask

  task automatic test_random_texts();
    live_chars = 0;
    while (live_chars < 20) send_text($urandom_range(0, 3), pick_tail());
  endtask

  task automatic test_drain_pause();
    send_text(2, TAIL_PAD1);
    in_tvalid <= 1'b0;
    wait_drained();
    send_text(1, TAIL_PAD2);
    in_tvalid <= 1'b0;
    wait_drained();
    send_text(2, TAIL_CLEAN);
  endtask

  task automatic test_steady_stream();
    idling = 1'b0;
    repeat (3) send_text($urandom_range(1, 3), pick_tail());
  endtask

  // random stalls on the result side
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (idling && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        report_error($sformatf("unexpected result: tdata %04h tuser %0d tlast %0d",
                               out_tdata, out_tuser, out_tlast));
      end else begin
        want = pending_results.pop_front();
        if (out_tuser[0] !== want.kind || out_tdata[7:0] !== want.data ||
            out_tdata[9:8] !== want.status || out_tdata[15:10] !== 6'd0 ||
            out_tlast !== want.last)
          report_error($sformatf(
            "exp kind %0d byte %02h st %0d last %0d, got tuser %0d tdata %04h tlast %0d",
            want.kind, want.data, want.status, want.last, out_tuser, out_tdata, out_tlast));
      end
    end
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = 8'h00;
    in_tuser = 1'b0;
    in_tlast = 1'b0;
    errors = 0;
    live_chars = 0;
    idling = 1'b1;
    clear_quad();
    text_done = 1'b0;
    text_code = b64d_pkg::ST_NOPAD;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_directed();
    test_random_texts();
    test_drain_pause();
    test_steady_stream();

    in_tvalid <= 1'b0;
    wait_drained();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+design
design/b64d_pkg.sv
design/b64d_quad.sv
design/b64d_outq.sv
design/base64_decoder.sv
dv/base64_decoder_test.sv
